// ----- src/ps2mct_pkg.sv -----
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int COL_RESET   = 40;
    localparam int ROW_RESET   = 12;
    localparam int BYTE_COUNT_W = 2;

    // Register map, byte addresses
    localparam logic ADDR_WHEEL_ENABLE = 1'b0;

    // Header bits that carry the ninth (sign) bit of each motion value
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    typedef enum logic [1:0] {
        SCROLL_NONE = 2'd0,
        SCROLL_DOWN = 2'd1,
        SCROLL_UP   = 2'd2
    } scroll_t;

    typedef struct packed {
        logic       aux_flag;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [COL_W-1:0] old_col;
        logic [ROW_W-1:0] old_row;
        logic [COL_W-1:0] new_col;
        logic [ROW_W-1:0] new_row;
        logic [1:0]       scroll;
    } out_t;

    // Completed packet handed from the assembler to the cursor unit
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] xbyte;
        logic [7:0] ybyte;
        scroll_t    scroll;
    } pkt_t;

endpackage

// ----- src/ps2_mouse_cursor_tracker.sv -----
// Top level of the PS/2 mouse cursor tracker: channels, register port, checks.
//
// Decodes PS/2 auxiliary-port bytes into cursor moves on an 80x25 text screen.
// Each request on the s_ channel carries one byte and its aux flag; bytes with
// the flag clear are dropped. Accepted bytes build 3-byte packets, or 4-byte
// packets when wheel_enable (APB address 0, bit 0) is set. The byte that
// completes a packet yields one request on the m_ channel with the old and new
// cursor cells and a scroll command (none, down for a positive wheel byte, up
// for a negative one). Motion is halved toward zero, X added to the column and
// Y subtracted from the row, both clamped to 0..MAX_COL and 0..MAX_ROW; the
// cursor starts at column 40, row 12. Header sync and overflow bits are not
// checked. Throughput is one byte per clock while no result waits on m_ready:
// an input register feeds one pass of decode, halve, add and clamp logic into
// the result register. The result register alone sets back-pressure: while a
// result waits on m_ready, bytes that do not complete a packet still flow in.
// Change wheel_enable only while idle.
module ps2_mouse_cursor_tracker #(
    parameter int MAX_COL = 79,
    parameter int MAX_ROW = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    // byte channel
    input  logic              s_valid,
    output logic              s_ready,
    input  ps2mct_pkg::in_t   s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output ps2mct_pkg::out_t  m_data,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic             wheel_enable_reg;
    logic             in_valid_reg, in_valid_next;
    ps2mct_pkg::in_t  in_data_reg;
    logic             m_valid_reg, m_valid_next;
    ps2mct_pkg::out_t m_data_reg;
    logic             pkt_done;
    logic             out_free;
    logic             consume;
    logic             out_load;
    logic             s_take;
    ps2mct_pkg::pkt_t pkt;
    ps2mct_pkg::out_t result;

    // Register port: zero wait states, single register
    assign pready = 1'b1;
    assign prdata = (paddr == ps2mct_pkg::ADDR_WHEEL_ENABLE) ? {31'b0, wheel_enable_reg}
                                                             : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_enable_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr == ps2mct_pkg::ADDR_WHEEL_ENABLE) begin
            wheel_enable_reg <= pwdata[0];
        end
    end

    // Handshake: a byte that makes no result never waits on the output side
    assign out_free = !m_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!pkt_done || out_free);
    assign out_load = consume && pkt_done;
    assign s_ready  = !in_valid_reg || consume;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Input register: hold the byte until the decode pass takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    ps2mct_assembler u_assembler (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (consume),
        .in_byte      (in_data_reg),
        .wheel_enable (wheel_enable_reg),
        .pkt_done     (pkt_done),
        .pkt          (pkt)
    );

    ps2mct_cursor #(
        .MAX_COL (MAX_COL),
        .MAX_ROW (MAX_ROW)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (out_load),
        .pkt     (pkt),
        .result  (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten while stalled");

    // Loading a result always presents it on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("loaded result not presented");

    // Without a wheel no scroll command is ever issued
    a_no_wheel_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !wheel_enable_reg) |=> (m_data.scroll == ps2mct_pkg::SCROLL_NONE))
        else $error("scroll issued with wheel disabled");

    // Back-pressure on bytes only comes from a completing packet and a full output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && pkt_done && m_valid && !m_ready))
        else $error("byte channel stalled without cause");

endmodule

// ----- src/ps2mct_assembler.sv -----
// Packet assembler: collects aux bytes into 3- or 4-byte mouse packets.
module ps2mct_assembler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  ps2mct_pkg::in_t    in_byte,
    input  logic               wheel_enable,
    output logic               pkt_done,
    output ps2mct_pkg::pkt_t   pkt
);

    logic [ps2mct_pkg::BYTE_COUNT_W-1:0] byte_count_reg;
    logic [ps2mct_pkg::BYTE_COUNT_W-1:0] byte_count_next;
    logic [ps2mct_pkg::BYTE_COUNT_W-1:0] last_count;
    logic [7:0]                          bytes_reg [3];
    logic                                store;

    assign last_count = wheel_enable ? 2'd3 : 2'd2;
    assign pkt_done   = in_byte.aux_flag && (byte_count_reg >= last_count);
    assign store      = take && in_byte.aux_flag;

    always_comb begin
        if (!store) begin
            byte_count_next = byte_count_reg;
        end else if (pkt_done) begin
            byte_count_next = '0;
        end else begin
            byte_count_next = byte_count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    // Packet bytes: header, X, Y. The completing byte is Y (no wheel) or the wheel.
    always_ff @(posedge aclk) begin
        if (store) begin
            if (!pkt_done) begin
                case (byte_count_reg)
                    2'd0:    bytes_reg[0] <= in_byte.data_byte;
                    2'd1:    bytes_reg[1] <= in_byte.data_byte;
                    2'd2:    bytes_reg[2] <= in_byte.data_byte;
                    default: bytes_reg[0] <= bytes_reg[0];
                endcase
            end else if (!wheel_enable) begin
                bytes_reg[2] <= in_byte.data_byte;
            end
        end
    end

    always_comb begin
        pkt.hdr   = bytes_reg[0];
        pkt.xbyte = bytes_reg[1];
        pkt.ybyte = wheel_enable ? bytes_reg[2] : in_byte.data_byte;
        if (!wheel_enable || in_byte.data_byte == 8'h00) begin
            pkt.scroll = ps2mct_pkg::SCROLL_NONE;
        end else if (in_byte.data_byte[7]) begin
            pkt.scroll = ps2mct_pkg::SCROLL_UP;
        end else begin
            pkt.scroll = ps2mct_pkg::SCROLL_DOWN;
        end
    end

endmodule

// ----- src/ps2mct_cursor.sv -----
// Cursor unit: halves motion, moves and clamps the text cursor, forms the result.
module ps2mct_cursor #(
    parameter int MAX_COL = 79,
    parameter int MAX_ROW = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ps2mct_pkg::pkt_t  pkt,
    output ps2mct_pkg::out_t  result
);

    localparam int COL_TOP = (MAX_COL > ps2mct_pkg::COL_RESET) ? MAX_COL
                                                               : ps2mct_pkg::COL_RESET;
    localparam int ROW_TOP = (MAX_ROW > ps2mct_pkg::ROW_RESET) ? MAX_ROW
                                                               : ps2mct_pkg::ROW_RESET;
    localparam int CW  = $clog2(COL_TOP + 1);
    localparam int RW  = $clog2(ROW_TOP + 1);
    localparam int CSW = ((CW > 8) ? CW : 8) + 2;
    localparam int RSW = ((RW > 8) ? RW : 8) + 2;

    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic signed [8:0]     dx, dy, dx_adj, dy_adj;
    logic signed [7:0]     half_x, half_y;
    logic signed [CSW-1:0] col_sum;
    logic signed [RSW-1:0] row_sum;

    // 9-bit motion; add one to negatives before the shift to round toward zero
    always_comb begin
        dx     = $signed({pkt.hdr[ps2mct_pkg::HDR_X_SIGN], pkt.xbyte});
        dy     = $signed({pkt.hdr[ps2mct_pkg::HDR_Y_SIGN], pkt.ybyte});
        dx_adj = dx + $signed({8'b0, dx[8]});
        dy_adj = dy + $signed({8'b0, dy[8]});
        half_x = 8'(dx_adj >>> 1);
        half_y = 8'(dy_adj >>> 1);
        col_sum = CSW'($signed({1'b0, col_reg})) + CSW'(half_x);
        row_sum = RSW'($signed({1'b0, row_reg})) - RSW'(half_y);
    end

    always_comb begin
        if (col_sum < 0) begin
            col_next = '0;
        end else if (col_sum > CSW'(MAX_COL)) begin
            col_next = CW'(MAX_COL);
        end else begin
            col_next = col_sum[CW-1:0];
        end
        if (row_sum < 0) begin
            row_next = '0;
        end else if (row_sum > RSW'(MAX_ROW)) begin
            row_next = RW'(MAX_ROW);
        end else begin
            row_next = row_sum[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= CW'(ps2mct_pkg::COL_RESET);
            row_reg <= RW'(ps2mct_pkg::ROW_RESET);
        end else if (fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb begin
        result.old_col = ps2mct_pkg::COL_W'(col_reg);
        result.old_row = ps2mct_pkg::ROW_W'(row_reg);
        result.new_col = ps2mct_pkg::COL_W'(col_next);
        result.new_row = ps2mct_pkg::ROW_W'(row_next);
        result.scroll  = pkt.scroll;
    end

endmodule
